// File: hdl/pqft_pkg.sv
package pqft_pkg;

   localparam int CAPACITY      = 16;
   localparam int PRIORITY_BITS = 8;
   localparam int ID_BITS       = 16;
   localparam int OCC_W         = 5;
   localparam int STATUS_W      = 2;

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);

   localparam logic ACT_ENQUEUE = 1'b0;
   localparam logic ACT_DEQUEUE = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_SHIFT,
      SEQ_PLACE,
      SEQ_HEAD,
      SEQ_EMIT
   } seq_state_type;

   typedef struct packed {
      logic [PRIORITY_BITS-1:0] prio;
      logic [ID_BITS-1:0]       id;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic                     out_valid;
      logic [PRIORITY_BITS-1:0] out_priority;
      logic [ID_BITS-1:0]       out_id;
      status_type               status;
      logic [OCC_W-1:0]         occupancy;
   } result_type;

   typedef struct packed {
      logic       done;
      result_type result;
   } seq_out_type;

   // Maps a logical queue position onto a physical slot of the circular store.
   function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] base,
                                                 input logic [CNT_W-1:0] off);
      logic [CNT_W:0] sum;
      sum = (CNT_W + 1)'(base) + (CNT_W + 1)'(off);
      if (sum >= (CNT_W + 1)'(CAPACITY)) begin
         sum = sum - (CNT_W + 1)'(CAPACITY);
      end
      return sum[IDX_W-1:0];
   endfunction

endpackage

// File: hdl/pqft_req_if.sv
interface pqft_req_if import pqft_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     action;
   logic [PRIORITY_BITS-1:0] task_priority;
   logic [ID_BITS-1:0]       task_id;

   modport source (output valid, output action, output task_priority, output task_id,
                   input ready);
   modport sink (input valid, input action, input task_priority, input task_id,
                 output ready);
endinterface

// File: hdl/pqft_rsp_if.sv
interface pqft_rsp_if import pqft_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     out_valid;
   logic [PRIORITY_BITS-1:0] out_priority;
   logic [ID_BITS-1:0]       out_id;
   logic [STATUS_W-1:0]      status;
   logic [OCC_W-1:0]         occupancy;

   modport source (output valid, output out_valid, output out_priority, output out_id,
                   output status, output occupancy, input ready);
   modport sink (input valid, input out_valid, input out_priority, input out_id,
                 input status, input occupancy, output ready);
endinterface

// File: hdl/pqft_ram.sv
module pqft_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/pqft_seq.sv
module pqft_seq import pqft_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   pqft_req_if.sink    req_ch,
   input  logic        out_free,
   output seq_out_type seq_out
);

   seq_state_type    state_ff, state_in;
   logic [IDX_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] pos_ff, pos_in;
   entry_type        new_entry_ff, new_entry_in;
   result_type       res_ff, res_in;

   logic             accept;
   logic             is_full;
   logic             is_empty;
   logic             prio_ge;
   entry_type        req_entry;
   entry_type        rd_entry;
   logic [CNT_W-1:0] rd_off;
   logic [CNT_W-1:0] wr_off;
   logic [IDX_W-1:0] rd_addr;
   logic [IDX_W-1:0] wr_addr;
   logic             wr_en;
   entry_type        wr_data;

   assign req_ch.ready = (state_ff == SEQ_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;
   assign is_full      = (count_ff == CNT_W'(CAPACITY));
   assign is_empty     = (count_ff == '0);
   assign req_entry    = '{prio: req_ch.task_priority, id: req_ch.task_id};

   // The single comparator walks the queue from the tail toward the head.
   assign prio_ge = (rd_entry.prio >= new_entry_ff.prio);

   assign rd_addr = wrap_add(head_ff, rd_off);
   assign wr_addr = wrap_add(head_ff, wr_off);

   pqft_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (CAPACITY)
   ) u_slots (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_entry)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         SEQ_IDLE: begin
            if (accept) begin
               if (req_ch.action == ACT_ENQUEUE) begin
                  state_in = (is_full || is_empty) ? SEQ_EMIT : SEQ_SHIFT;
               end else begin
                  state_in = is_empty ? SEQ_EMIT : SEQ_HEAD;
               end
            end
         end
         SEQ_SHIFT: begin
            if (prio_ge) begin
               state_in = SEQ_EMIT;
            end else if (pos_ff == CNT_W'(1)) begin
               state_in = SEQ_PLACE;
            end
         end
         SEQ_PLACE: state_in = SEQ_EMIT;
         SEQ_HEAD:  state_in = SEQ_EMIT;
         SEQ_EMIT: begin
            if (out_free) begin
               state_in = SEQ_IDLE;
            end
         end
         default: state_in = SEQ_IDLE;
      endcase
   end

   always_comb begin
      head_in      = head_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      new_entry_in = new_entry_ff;
      res_in       = res_ff;
      rd_off       = pos_ff - CNT_W'(2);
      wr_off       = pos_ff;
      wr_en        = 1'b0;
      wr_data      = new_entry_ff;
      case (state_ff)
         SEQ_IDLE: begin
            wr_off  = '0;
            wr_data = req_entry;
            rd_off  = (req_ch.action == ACT_DEQUEUE) ? '0 : count_ff - CNT_W'(1);
            if (accept) begin
               new_entry_in = req_entry;
               pos_in       = count_ff;
               res_in       = '{out_valid: 1'b0, out_priority: '0, out_id: '0,
                                status: STATUS_OK, occupancy: '0};
               if (req_ch.action == ACT_ENQUEUE) begin
                  if (is_full) begin
                     res_in.status = STATUS_FULL;
                  end else if (is_empty) begin
                     wr_en    = 1'b1;
                     count_in = count_ff + CNT_W'(1);
                  end
               end else if (is_empty) begin
                  res_in.status = STATUS_EMPTY;
               end
            end
         end
         SEQ_SHIFT: begin
            wr_en = 1'b1;
            if (prio_ge) begin
               count_in = count_ff + CNT_W'(1);
            end else begin
               // Move the lower-priority task one place toward the tail.
               wr_data = rd_entry;
               pos_in  = pos_ff - CNT_W'(1);
            end
         end
         SEQ_PLACE: begin
            wr_en    = 1'b1;
            count_in = count_ff + CNT_W'(1);
         end
         SEQ_HEAD: begin
            res_in.out_valid    = 1'b1;
            res_in.out_priority = rd_entry.prio;
            res_in.out_id       = rd_entry.id;
            head_in             = wrap_add(head_ff, CNT_W'(1));
            count_in            = count_ff - CNT_W'(1);
         end
         SEQ_EMIT: begin
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      seq_out.done             = (state_ff == SEQ_EMIT);
      seq_out.result           = res_ff;
      seq_out.result.occupancy = OCC_W'(count_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff       <= pos_in;
      new_entry_ff <= new_entry_in;
      res_ff       <= res_in;
   end

endmodule

// File: hdl/priority_queue_fifo_ties.sv
// A flagged request or an enqueue into an empty queue goes straight to the emit state,
// a dequeue passes through the head state first, and an enqueue that moves m held tasks
// (m up to 15) shifts them toward the tail one at a time before the new task is placed.
// One request is in work at a time; the single slot RAM port pair and the comparator
// are revisited once per moved task; a new request waits until the last result is loaded.
// A response waiting on the output register holds the next result at its last step.
// Synchronous reset empties the queue at once; slot contents are not cleared.
module priority_queue_fifo_ties import pqft_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   pqft_req_if.sink   req_ch,
   pqft_rsp_if.source rsp_ch
);

   seq_out_type seq_out;
   logic        out_free;
   logic        load;

   logic        rsp_valid_ff, rsp_valid_in;
   result_type  rsp_data_ff, rsp_data_in;

   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign load     = seq_out.done && out_free;

   pqft_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch),
      .out_free (out_free),
      .seq_out  (seq_out)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = seq_out.result;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.out_valid    = rsp_data_ff.out_valid;
   assign rsp_ch.out_priority = rsp_data_ff.out_priority;
   assign rsp_ch.out_id       = rsp_data_ff.out_id;
   assign rsp_ch.status       = rsp_data_ff.status;
   assign rsp_ch.occupancy    = rsp_data_ff.occupancy;

endmodule

// File: hdl/pqft_checker.sv
module pqft_checker import pqft_pkg::*; (
   input logic                     clock,
   input logic                     reset,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic                     rsp_out_valid,
   input logic [PRIORITY_BITS-1:0] rsp_out_priority,
   input logic [ID_BITS-1:0]       rsp_out_id,
   input logic [STATUS_W-1:0]      rsp_status,
   input logic [OCC_W-1:0]         rsp_occupancy
);

   // A stalled response keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_priority)
         && $stable(rsp_out_id) && $stable(rsp_status) && $stable(rsp_occupancy))
   else $error("stalled response changed");

   // A delivered task always comes with an ok status.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_valid |-> rsp_status == STATUS_OK)
   else $error("delivered task without ok status");

   // A dropped enqueue means the queue was full and stays full.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_FULL |->
         rsp_occupancy == OCC_W'(CAPACITY) && !rsp_out_valid)
   else $error("full flag with queue not full");

   // A dequeue on an empty queue leaves it empty and delivers nothing.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_EMPTY |-> rsp_occupancy == '0 && !rsp_out_valid)
   else $error("empty flag with tasks held");

   // No response is pending right after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
   else $error("response valid after reset");

endmodule

bind priority_queue_fifo_ties pqft_checker u_pqft_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_out_valid    (rsp_ch.out_valid),
   .rsp_out_priority (rsp_ch.out_priority),
   .rsp_out_id       (rsp_ch.out_id),
   .rsp_status       (rsp_ch.status),
   .rsp_occupancy    (rsp_ch.occupancy)
);

// File: tb/tb_priority_queue_fifo_ties.sv
module tb_priority_queue_fifo_ties;
   import pqft_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int RSP_HOLD_CYCLES = 150;
   localparam int BLOCK_LEN       = 32;
   localparam int PHASE_OPS       = 216;

   typedef struct packed {
      logic                     act;
      logic [PRIORITY_BITS-1:0] prio;
      logic [ID_BITS-1:0]       id;
      logic [7:0]               reps;
      logic                     typed;
      result_type               want;
   } opening_op_type;

   // Rows with typed set carry their own expected response; the rest go through
   // the queue model. Repeated rows bump the id by one per repetition.
   localparam opening_op_type OPENING_OPS[16] = '{
      '{ACT_DEQUEUE, 8'd0,   16'h0000, 8'd1,  1'b1, '{1'b0, 8'd0, 16'h0, STATUS_EMPTY, 5'd0}},
      '{ACT_ENQUEUE, 8'd255, 16'hFFFF, 8'd1,  1'b1, '{1'b0, 8'd0, 16'h0, STATUS_OK, 5'd1}},
      '{ACT_ENQUEUE, 8'd0,   16'h0000, 8'd1,  1'b0, '0},
      '{ACT_ENQUEUE, 8'd255, 16'h0001, 8'd1,  1'b0, '0},
      '{ACT_ENQUEUE, 8'd128, 16'h5555, 8'd1,  1'b0, '0},
      '{ACT_ENQUEUE, 8'd0,   16'hAAAA, 8'd1,  1'b0, '0},
      '{ACT_DEQUEUE, 8'd255, 16'h0000, 8'd1,  1'b1, '{1'b1, 8'd255, 16'hFFFF, STATUS_OK, 5'd4}},
      '{ACT_DEQUEUE, 8'd0,   16'hFFFF, 8'd4,  1'b0, '0},
      '{ACT_DEQUEUE, 8'd0,   16'h0000, 8'd1,  1'b1, '{1'b0, 8'd0, 16'h0, STATUS_EMPTY, 5'd0}},
      '{ACT_ENQUEUE, 8'd7,   16'h0100, 8'd16, 1'b0, '0},
      '{ACT_ENQUEUE, 8'd255, 16'hBEEF, 8'd1,  1'b1, '{1'b0, 8'd0, 16'h0, STATUS_FULL, 5'd16}},
      '{ACT_DEQUEUE, 8'd0,   16'h0000, 8'd16, 1'b0, '0},
      '{ACT_DEQUEUE, 8'd0,   16'h0000, 8'd1,  1'b1, '{1'b0, 8'd0, 16'h0, STATUS_EMPTY, 5'd0}},
      '{ACT_ENQUEUE, 8'd1,   16'h8000, 8'd1,  1'b0, '0},
      '{ACT_ENQUEUE, 8'd2,   16'h7FFF, 8'd1,  1'b0, '0},
      '{ACT_DEQUEUE, 8'd0,   16'h0000, 8'd2,  1'b0, '0}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   pqft_req_if req_ch ();
   pqft_rsp_if rsp_ch ();

   priority_queue_fifo_ties i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   entry_type   held_tasks[$];
   result_type  pending_results[$];
   int unsigned send_gap_pct = 16;
   int unsigned recv_gap_pct = 58;
   logic        hold_off_req = 1'b0;
   int          mismatch_count = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Queue model: an enqueue lands after every held task of greater or equal
   // priority, so ties leave in arrival order.
   function automatic result_type serve_op(input logic act,
                                           input logic [PRIORITY_BITS-1:0] prio,
                                           input logic [ID_BITS-1:0] id);
      result_type res;
      entry_type  head;
      int         pos;
      res = '0;
      res.status = STATUS_OK;
      if (act == ACT_ENQUEUE) begin
         if (held_tasks.size() >= CAPACITY) begin
            res.status = STATUS_FULL;
         end else begin
            pos = 0;
            while (pos < held_tasks.size() && held_tasks[pos].prio >= prio) begin
               pos++;
            end
            head.prio = prio;
            head.id   = id;
            held_tasks.insert(pos, head);
         end
      end else begin
         if (held_tasks.size() == 0) begin
            res.status = STATUS_EMPTY;
         end else begin
            head = held_tasks.pop_front();
            res.out_valid    = 1'b1;
            res.out_priority = head.prio;
            res.out_id       = head.id;
         end
      end
      res.occupancy = OCC_W'(held_tasks.size());
      return res;
   endfunction

   task automatic issue_op(input logic act, input logic [PRIORITY_BITS-1:0] prio,
                           input logic [ID_BITS-1:0] id, input logic typed,
                           input result_type want);
      result_type predicted;
      while ($urandom_range(99) < send_gap_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.action        <= act;
      req_ch.task_priority <= prio;
      req_ch.task_id       <= id;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      predicted = serve_op(act, prio, id);
      pending_results.push_back(typed ? want : predicted);
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (pending_results.size() == 0) begin
            $error("response transaction with no request outstanding");
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            check_field("out_valid", 32'(want.out_valid), 32'(rsp_ch.out_valid));
            check_field("out_priority", 32'(want.out_priority), 32'(rsp_ch.out_priority));
            check_field("out_id", 32'(want.out_id), 32'(rsp_ch.out_id));
            check_field("status", 32'(want.status), 32'(rsp_ch.status));
            check_field("occupancy", 32'(want.occupancy), 32'(rsp_ch.occupancy));
         end
      end
   end

   // Response side: random ready, with one long hold-off on request.
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
         end
         rsp_ch.ready <= ($urandom_range(99) >= recv_gap_pct);
      end
   end

   initial begin
      int                       enq_bias;
      int                       guard;
      logic                     act;
      logic [PRIORITY_BITS-1:0] prio;
      logic [ID_BITS-1:0]       id;

      req_ch.valid         <= 1'b0;
      req_ch.action        <= ACT_ENQUEUE;
      req_ch.task_priority <= '0;
      req_ch.task_id       <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < $size(OPENING_OPS); r++) begin
         for (int k = 0; k < OPENING_OPS[r].reps; k++) begin
            issue_op(OPENING_OPS[r].act, OPENING_OPS[r].prio,
                     OPENING_OPS[r].id + ID_BITS'(k), OPENING_OPS[r].typed,
                     OPENING_OPS[r].want);
         end
      end

      enq_bias = 50;
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_gap_pct = 16;
               recv_gap_pct = 58;
            end
            1: begin
               send_gap_pct = 58;
               recv_gap_pct = 16;
            end
            default: begin
               send_gap_pct = 0;
               recv_gap_pct = 0;
               hold_off_req = 1'b1;
            end
         endcase
         for (int n = 0; n < PHASE_OPS; n++) begin
            // Blocks of mostly enqueues, mostly dequeues or an even mix drive the
            // queue to full and back to empty.
            if (n % BLOCK_LEN == 0) begin
               case ($urandom_range(2))
                  0: enq_bias = 15;
                  1: enq_bias = 50;
                  default: enq_bias = 85;
               endcase
            end
            act = ($urandom_range(99) < enq_bias) ? ACT_ENQUEUE : ACT_DEQUEUE;
            case ($urandom_range(9))
               0: prio = '0;
               1: prio = '1;
               2, 3, 4, 5: prio = PRIORITY_BITS'($urandom_range(3));
               default: prio = PRIORITY_BITS'($urandom);
            endcase
            id = ID_BITS'($urandom);
            issue_op(act, prio, id, 1'b0, '0);
         end
      end
      req_ch.valid <= 1'b0;

      guard = 0;
      while (pending_results.size() != 0 && guard < 20000) begin
         @(posedge clock);
         guard++;
      end
      repeat (40) @(posedge clock);
      if (pending_results.size() != 0) begin
         $error("%0d expected responses never arrived", pending_results.size());
         mismatch_count++;
      end

      if (mismatch_count == 0) begin
         $display("priority_queue_fifo_ties regression: pass");
      end else begin
         $display("priority_queue_fifo_ties regression: fail");
      end
      $finish;
   end

   initial begin
      #1ms;
      $display("priority_queue_fifo_ties regression: fail");
      $finish;
   end

endmodule
